// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros shared by the sorted squares merge design
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/ssm_pkg.sv =====
// ----------------------------------------------------------------------------
// ssm_pkg
// shared constants, state codes and control structs of the sorted squares merge
// ----------------------------------------------------------------------------
package ssm_pkg;

  // capacity of one run
  localparam int MAX_LEN = 64;
  localparam int ADDR_W  = $clog2(MAX_LEN);
  localparam int CNT_W   = $clog2(MAX_LEN + 1);

  // field widths
  localparam int VAL_W = 16;
  localparam int MAG_W = 16;
  localparam int SQ_W  = 31;

  // controller states, one-hot
  typedef enum logic [5:0] {
    ST_LOAD   = 6'b000001,
    ST_PRIME  = 6'b000010,
    ST_MERGE  = 6'b000100,
    ST_FLUSH  = 6'b001000,
    ST_SETTLE = 6'b010000,
    ST_EMIT   = 6'b100000
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic prime;
    logic step;
    logic emit;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic merge_last;
    logic emit_done;
  } status_t;

endpackage

// ===== sv/ssm_ram.sv =====
// ----------------------------------------------------------------------------
// ssm_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module ssm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/ssm_ctrl.sv =====
// ----------------------------------------------------------------------------
// ssm_ctrl
// run controller: load, merge, flush and emit sequencing
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ssm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             final_item,
  output logic             in_stall,
  input  ssm_pkg::status_t status,
  output ssm_pkg::cmd_t    cmd
);

  ssm_pkg::state_t state;
  ssm_pkg::state_t state_next;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ssm_pkg::ST_LOAD: begin
        if (in_valid && final_item) begin
          state_next = ssm_pkg::ST_PRIME;
        end
      end
      ssm_pkg::ST_PRIME: begin
        state_next = ssm_pkg::ST_MERGE;
      end
      ssm_pkg::ST_MERGE: begin
        if (status.merge_last) begin
          state_next = ssm_pkg::ST_FLUSH;
        end
      end
      ssm_pkg::ST_FLUSH: begin
        state_next = ssm_pkg::ST_SETTLE;
      end
      ssm_pkg::ST_SETTLE: begin
        state_next = ssm_pkg::ST_EMIT;
      end
      ssm_pkg::ST_EMIT: begin
        if (status.emit_done) begin
          state_next = ssm_pkg::ST_LOAD;
        end
      end
      default: begin
        state_next = ssm_pkg::ST_LOAD;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ssm_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // commands
  always_comb begin
    cmd.accept = (state == ssm_pkg::ST_LOAD) && in_valid;
    cmd.prime  = (state == ssm_pkg::ST_PRIME);
    cmd.step   = (state == ssm_pkg::ST_MERGE);
    cmd.emit   = (state == ssm_pkg::ST_EMIT);
  end

  assign in_stall = (state != ssm_pkg::ST_LOAD);

  // a marked beat always starts the merge
  `ASSERT_NEXT(a_final_starts_merge, clk, rst, cmd.accept && final_item, state == ssm_pkg::ST_PRIME, "final beat did not start merge")
  // the last result hands control back to loading
  `ASSERT_NEXT(a_emit_done_to_load, clk, rst, status.emit_done, !in_stall, "input not reopened after run")

endmodule

// ===== sv/ssm_datapath.sv =====
// ----------------------------------------------------------------------------
// ssm_datapath
// element stores, two-pointer merge, square pipeline and result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ssm_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  ssm_pkg::cmd_t                     cmd,
  output ssm_pkg::status_t                  status,
  input  logic signed [ssm_pkg::VAL_W-1:0]  value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ssm_pkg::SQ_W-1:0]          square,
  output logic                              last_result,
  output logic                              overflowed
);

  // run bookkeeping
  logic [ssm_pkg::CNT_W-1:0]  count;
  logic                       ovf;
  logic                       has_room;
  logic [ssm_pkg::ADDR_W-1:0] last_idx;

  // merge pointers
  logic [ssm_pkg::ADDR_W-1:0] lo;
  logic [ssm_pkg::ADDR_W-1:0] lo_next;
  logic [ssm_pkg::ADDR_W-1:0] hi;
  logic [ssm_pkg::ADDR_W-1:0] hi_next;
  logic [ssm_pkg::CNT_W-1:0]  dst;
  logic [ssm_pkg::VAL_W-1:0]  rd_left;
  logic [ssm_pkg::VAL_W-1:0]  rd_right;
  logic [ssm_pkg::MAG_W-1:0]  mag_left;
  logic [ssm_pkg::MAG_W-1:0]  mag_right;
  logic                       take_left;

  // square pipeline
  logic                        wr_pending;
  logic [ssm_pkg::ADDR_W-1:0]  wr_addr;
  logic [ssm_pkg::MAG_W-1:0]   wr_mag;
  logic [2*ssm_pkg::MAG_W-1:0] sq_full;

  // emit side
  logic [ssm_pkg::ADDR_W-1:0] ptr;
  logic [ssm_pkg::ADDR_W-1:0] ptr_next;
  logic [ssm_pkg::SQ_W-1:0]   sq_rd;
  logic                       emit_fire;
  logic                       emit_last;

  function automatic logic [ssm_pkg::MAG_W-1:0] magnitude(
    input logic [ssm_pkg::VAL_W-1:0] v
  );
    logic [ssm_pkg::MAG_W-1:0] m;
    m = ssm_pkg::MAG_W'(v);
    if (v[ssm_pkg::VAL_W-1]) begin
      m = ssm_pkg::MAG_W'(~v) + ssm_pkg::MAG_W'(1);
    end
    return m;
  endfunction

  assign has_room = (count < ssm_pkg::CNT_W'(ssm_pkg::MAX_LEN));
  assign last_idx = ssm_pkg::ADDR_W'(count - ssm_pkg::CNT_W'(1));

  // element store, one copy per merge pointer
  ssm_ram #(
    .WIDTH (ssm_pkg::VAL_W),
    .DEPTH (ssm_pkg::MAX_LEN)
  ) u_elem_left (
    .clk     (clk),
    .wr_en   (cmd.accept && has_room),
    .wr_addr (count[ssm_pkg::ADDR_W-1:0]),
    .wr_data (value),
    .rd_addr (lo_next),
    .rd_data (rd_left)
  );

  ssm_ram #(
    .WIDTH (ssm_pkg::VAL_W),
    .DEPTH (ssm_pkg::MAX_LEN)
  ) u_elem_right (
    .clk     (clk),
    .wr_en   (cmd.accept && has_room),
    .wr_addr (count[ssm_pkg::ADDR_W-1:0]),
    .wr_data (value),
    .rd_addr (hi_next),
    .rd_data (rd_right)
  );

  // compare magnitudes at both ends, ties go left
  assign mag_left  = magnitude(rd_left);
  assign mag_right = magnitude(rd_right);
  assign take_left = (mag_left >= mag_right);

  // pointer update, read addresses follow the next pointers
  always_comb begin
    lo_next = lo;
    hi_next = hi;
    if (cmd.prime) begin
      lo_next = '0;
      hi_next = last_idx;
    end else if (cmd.step) begin
      if (take_left) begin
        lo_next = lo + ssm_pkg::ADDR_W'(1);
      end else if (hi != '0) begin
        hi_next = hi - ssm_pkg::ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    lo <= lo_next;
    hi <= hi_next;
  end

  // destination counter and square stage register
  always_ff @(posedge clk) begin
    if (cmd.prime) begin
      dst <= count;
    end else if (cmd.step) begin
      dst     <= dst - ssm_pkg::CNT_W'(1);
      wr_addr <= ssm_pkg::ADDR_W'(dst - ssm_pkg::CNT_W'(1));
      wr_mag  <= take_left ? mag_left : mag_right;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pending <= 1'b0;
    end else begin
      wr_pending <= cmd.step;
    end
  end

  assign status.merge_last = cmd.step && (dst == ssm_pkg::CNT_W'(1));

  // squaring ahead of the square store
  assign sq_full = (2 * ssm_pkg::MAG_W)'(wr_mag) * (2 * ssm_pkg::MAG_W)'(wr_mag);

  ssm_ram #(
    .WIDTH (ssm_pkg::SQ_W),
    .DEPTH (ssm_pkg::MAX_LEN)
  ) u_square (
    .clk     (clk),
    .wr_en   (wr_pending),
    .wr_addr (wr_addr),
    .wr_data (sq_full[ssm_pkg::SQ_W-1:0]),
    .rd_addr (ptr_next),
    .rd_data (sq_rd)
  );

  // emit pointer, read data always matches ptr once it has settled
  assign emit_fire = cmd.emit && (!out_valid || !out_stall);
  assign emit_last = (ptr == last_idx);
  assign status.emit_done = emit_fire && emit_last;

  always_comb begin
    ptr_next = ptr;
    if (emit_fire) begin
      ptr_next = emit_last ? '0 : ptr + ssm_pkg::ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else begin
      ptr <= ptr_next;
    end
  end

  // run count and overflow flag
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (status.emit_done) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (cmd.accept) begin
      if (has_room) begin
        count <= count + ssm_pkg::CNT_W'(1);
      end else begin
        ovf <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      square      <= sq_rd;
      last_result <= emit_last;
      overflowed  <= ovf;
    end
  end

  // the stored count never passes capacity
  `ASSERT_ALWAYS(a_count_bound, clk, rst, count <= ssm_pkg::CNT_W'(ssm_pkg::MAX_LEN), "element count above capacity")
  // the two merge pointers never cross while stepping
  `ASSERT_ALWAYS(a_ptr_order, clk, rst, !cmd.step || (lo <= hi), "merge pointers crossed")
  // the write to the bottom slot is the last of the merge
  `ASSERT_NEXT(a_bottom_last, clk, rst, wr_pending && (wr_addr == '0), !wr_pending, "square write after bottom slot")

endmodule

// ===== sv/sorted_squares_merge.sv =====
// ----------------------------------------------------------------------------
// sorted_squares_merge
// squares of a sorted run of signed values, emitted in non-decreasing order
// ----------------------------------------------------------------------------
//
//   channel  handshake            payload
//   input    in_valid / in_stall  value, final_item
//   output   out_valid / out_stall square, last_result, overflowed
//
// loading takes one cycle per beat; a beat past 64 elements is dropped and flagged
// after the final beat: a priming state, one merge step per element (one pointer
// step per cycle, set by the registered reads of the two element store copies),
// square store flush and settle, then one result per cycle while out_stall is low
// the input is stalled from the final beat until the last result enters the
// output register; no clearing pass after reset, reset is synchronous
// ----------------------------------------------------------------------------
module sorted_squares_merge (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [ssm_pkg::VAL_W-1:0]  value,
  input  logic                              final_item,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ssm_pkg::SQ_W-1:0]          square,
  output logic                              last_result,
  output logic                              overflowed
);

  ssm_pkg::cmd_t    cmd;
  ssm_pkg::status_t status;

  // sequencing
  ssm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .final_item (final_item),
    .in_stall   (in_stall),
    .status     (status),
    .cmd        (cmd)
  );

  // storage, merge and result path
  ssm_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .square      (square),
    .last_result (last_result),
    .overflowed  (overflowed)
  );

endmodule
